[hdl/mph_pkg.sv]
`default_nettype none
package mph_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned HALF_W    = WORD_W / 2;
  localparam int unsigned PROD_W    = 2 * WORD_W;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CNT_W     = $clog2(PROD_W);
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [WORD_W-1:0] BASE_RESET    = 64'd257;
  localparam logic [WORD_W-1:0] MODULUS_RESET = 64'd1000000007;

  localparam logic [CFG_IDX_W-1:0] REG_POLY_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_MODULUS = 2'd1;

  localparam logic [CNT_W-1:0] MUL_LAST_STEP = CNT_W'(3);
  localparam logic [CNT_W-1:0] RED_LAST_STEP = CNT_W'(PROD_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic red_step;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic red_done;
    logic last;
  } status_t;

endpackage
`default_nettype wire

[hdl/mph_ctrl.sv]
`default_nettype none
module mph_ctrl
  import mph_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (status_i.mul_done) state_d = ST_RED;
      end
      ST_RED: begin
        if (status_i.red_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!status_i.last || slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MUL: cmd_o.mul_step = 1'b1;
      ST_RED: cmd_o.red_step = 1'b1;
      ST_DONE: begin
        if (!status_i.last) begin
          cmd_o.commit = 1'b1;
        end else if (slot_free) begin
          cmd_o.commit = 1'b1;
          cmd_o.emit   = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

[hdl/mph_datapath.sv]
`default_nettype none
module mph_datapath
  import mph_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  output status_t                   status_o,
  input  wire logic [BYTE_W-1:0]    data_byte_i,
  input  wire logic                 last_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [WORD_W-1:0]    cfg_data_i,
  output logic [WORD_W-1:0]         hash_value_o
);

  logic [WORD_W-1:0] base_q, modulus_q;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [WORD_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              last_q;
  logic [WORD_W-1:0] hash_q;

  logic [HALF_W-1:0] mul_a, mul_b;
  logic [WORD_W-1:0] pp;
  logic [1:0]        pp_pos;
  logic [PROD_W-1:0] pp_shifted;
  logic [WORD_W:0]   rem_shift, rem_sub;
  logic              rem_ge;

  assign mul_a      = cnt_q[1] ? acc_q[WORD_W-1:HALF_W]  : acc_q[HALF_W-1:0];
  assign mul_b      = cnt_q[0] ? base_q[WORD_W-1:HALF_W] : base_q[HALF_W-1:0];
  assign pp         = WORD_W'(mul_a) * WORD_W'(mul_b);
  assign pp_pos     = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
  assign pp_shifted = {{(PROD_W-WORD_W){1'b0}}, pp} << (HALF_W * pp_pos);

  assign rem_shift = {rem_q, prod_q[PROD_W-1]};
  assign rem_sub   = rem_shift - {1'b0, modulus_q};
  assign rem_ge    = rem_shift >= {1'b0, modulus_q};

  always_comb begin
    prod_d = prod_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    if (cmd_i.load) begin
      prod_d = {{(PROD_W-BYTE_W){1'b0}}, data_byte_i};
      rem_d  = '0;
      cnt_d  = '0;
    end
    if (cmd_i.mul_step) begin
      prod_d = prod_q + pp_shifted;
      cnt_d  = status_o.mul_done ? '0 : cnt_q + CNT_W'(1);
    end
    if (cmd_i.red_step) begin
      prod_d = prod_q << 1;
      rem_d  = rem_ge ? rem_sub[WORD_W-1:0] : rem_shift[WORD_W-1:0];
      cnt_d  = cnt_q + CNT_W'(1);
    end
    if (cmd_i.commit) begin
      acc_d = last_q ? '0 : rem_q;
    end
  end

  assign status_o.mul_done = cnt_q == MUL_LAST_STEP;
  assign status_o.red_done = cnt_q == RED_LAST_STEP;
  assign status_o.last     = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= BASE_RESET;
      modulus_q <= MODULUS_RESET;
      acc_q     <= '0;
      cnt_q     <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == REG_POLY_BASE)    base_q    <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == REG_HASH_MODULUS) modulus_q <= cfg_data_i;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
    if (cmd_i.load) last_q <= last_i;
    if (cmd_i.emit) hash_q <= rem_q;
  end

  assign hash_value_o = hash_q;

endmodule
`default_nettype wire

[hdl/modular_polynomial_hash_core.sv]
// Polynomial rolling hash by Horner's rule over a byte stream.
// Input channel (in_valid_i/in_ready_o): one message byte per item, last_i
// marks the final byte. Per byte: acc = (acc * poly_base + byte) mod modulus.
// Output channel (out_valid_o/out_ready_i): one hash item per message,
// produced by the final byte; the accumulator then clears for the next one.
// Configuration channel (cfg_valid_i/cfg_ready_o): index 0 writes poly_base,
// index 1 writes hash_modulus; other indexes are ignored. Always ready.
// Operation: each byte runs through four 32x32 partial products summed into a
// 128-bit product, a restoring reduction by the modulus at one bit per cycle,
// and a commit. in_ready_o is high only in the idle state, so a new byte is
// accepted only after the previous one has committed.
// The hash and out_valid_o are registered when the final byte commits.
// Reset: poly_base = 257, hash_modulus = 1000000007, accumulator = 0.
// Stall: a finished hash waits in the output register; further bytes are
// taken and processed meanwhile, and only the next final byte holds until
// the waiting hash is taken.
`default_nettype none
module modular_polynomial_hash_core
  import mph_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [BYTE_W-1:0]    data_byte_i,
  input  wire logic                 last_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [WORD_W-1:0]         hash_value_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [WORD_W-1:0]    cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  mph_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mph_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .data_byte_i  (data_byte_i),
    .last_i       (last_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .hash_value_o (hash_value_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("byte accepted while previous byte still in progress");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.mul_step, cmd.red_step, cmd.commit}))
    else $error("conflicting datapath commands");

  a_emit_commits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (cmd.commit && status.last))
    else $error("hash emitted without final-byte commit");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_valid_o)
    else $error("emitted hash not presented");

endmodule
`default_nettype wire

[tb/tb_modular_polynomial_hash_core.sv]
`timescale 1ns / 1ps
module tb_modular_polynomial_hash_core;
  import mph_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 160;
  localparam int unsigned RANDOM_ITEMS  = 700;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    data_byte = '0;
  logic                 last = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WORD_W-1:0]    hash_value;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;

  logic [WORD_W-1:0] mdl_base = BASE_RESET;
  logic [WORD_W-1:0] mdl_modulus = MODULUS_RESET;
  logic [WORD_W-1:0] mdl_acc = '0;
  logic [WORD_W-1:0] hash_expected[$];
  bit                stall_en = 1'b1;
  int                errors = 0;

  modular_polynomial_hash_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .data_byte_i  (data_byte),
    .last_i       (last),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .hash_value_o (hash_value),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [WORD_W-1:0] horner_step(logic [WORD_W-1:0] acc,
                                                    logic [BYTE_W-1:0] b);
    logic [PROD_W-1:0] wide;
    wide = PROD_W'(acc) * PROD_W'(mdl_base) + PROD_W'(b);
    if (mdl_modulus == '0) begin
      return wide[WORD_W-1:0];
    end
    return WORD_W'(wide % PROD_W'(mdl_modulus));
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  always @(posedge clk_i) begin
    if (out_valid && out_ready) begin
      if (hash_expected.size() == 0) begin
        $display("%0t unexpected hash: expected none actual %h", $time, hash_value);
        errors++;
      end else begin
        if (hash_value !== hash_expected[0]) begin
          $display("%0t hash mismatch: expected %h actual %h",
                   $time, hash_expected[0], hash_value);
          errors++;
        end
        void'(hash_expected.pop_front());
      end
    end
    out_ready <= stall_en ? ($urandom_range(99) >= 22) : 1'b1;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic l);
    while (stall_en && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last      <= l;
    do @(posedge clk_i); while (!in_ready);
    mdl_acc = horner_step(mdl_acc, b);
    if (l) begin
      hash_expected.push_back(mdl_acc);
      mdl_acc = '0;
    end
  endtask

  // hold the sender until every hash is out and the last byte has settled
  task automatic drain_results();
    in_valid <= 1'b0;
    while (hash_expected.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    while (stall_en && $urandom_range(99) < 22) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      REG_POLY_BASE:    mdl_base = val;
      REG_HASH_MODULUS: mdl_modulus = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_reset_values();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'hab, 1'b0);
    send_byte(8'hff, 1'b1);
    drain_results();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_POLY_BASE, '0);
    write_reg(REG_HASH_MODULUS, ALL_ONES);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h80, 1'b1);
    drain_results();
    write_reg(REG_POLY_BASE, ALL_ONES);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    drain_results();
    write_reg(REG_HASH_MODULUS, 64'd1);
    send_byte(8'ha5, 1'b1);
    drain_results();
    write_reg(REG_HASH_MODULUS, '0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    drain_results();
    write_reg(REG_SPARE_2, rand_word());
    write_reg(REG_SPARE_3, rand_word());
    send_byte(8'h01, 1'b1);
    drain_results();
  endtask

  task automatic test_modulus_change_mid_message();
    write_reg(REG_POLY_BASE, ALL_ONES);
    write_reg(REG_HASH_MODULUS, ALL_ONES);
    send_byte(8'hfe, 1'b0);
    send_byte(8'hc3, 1'b0);
    send_byte(8'h99, 1'b0);
    drain_results();
    write_reg(REG_HASH_MODULUS, 64'd3);
    write_reg(REG_POLY_BASE, 64'd1000003);
    send_byte(8'h5a, 1'b1);
    drain_results();
  endtask

  task automatic pick_config();
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] m;
    case ($urandom_range(5))
      0: b = '0;
      1: b = ALL_ONES;
      2: b = rand_word();
      3: b = WORD_W'($urandom_range(300, 2));
      4: b = WORD_W'($urandom());
      default: b = BASE_RESET;
    endcase
    case ($urandom_range(7))
      0: m = '0;
      1: m = 64'd1;
      2: m = ALL_ONES;
      3: m = rand_word();
      4: m = WORD_W'($urandom()) | 64'd1;
      5: m = WORD_W'($urandom_range(1000, 2));
      6: m = rand_word() | 64'h8000_0000_0000_0000;
      default: m = MODULUS_RESET;
    endcase
    if ($urandom_range(3) == 0) begin
      write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, rand_word());
    end
    write_reg(REG_POLY_BASE, b);
    write_reg(REG_HASH_MODULUS, m);
  endtask

  task automatic test_random_messages();
    int sent;
    int phase;
    int len;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      pick_config();
      stall_en = (phase != 3);
      repeat ($urandom_range(12, 4)) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(8, 1);
        for (int k = 0; k < len; k++) begin
          if (k > 0 && $urandom_range(39) == 0) begin
            drain_results();
            write_reg($urandom_range(1) ? REG_HASH_MODULUS : REG_POLY_BASE,
                      ($urandom_range(1)) ? rand_word() : WORD_W'($urandom_range(500, 0)));
          end
          send_byte(BYTE_W'($urandom()), k == len - 1);
          sent++;
        end
      end
      drain_results();
      stall_en = 1'b1;
      phase++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_register_extremes();
    test_modulus_change_mid_message();
    test_random_messages();
    drain_results();
    if (errors == 0 && hash_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
